@@ rtl/core/csrspmv_pkg.sv @@
package csrspmv_pkg;

    localparam int VECTOR_DEPTH_DEF = 1024;

    localparam int COL_W  = 10;
    localparam int VAL_W  = 32;
    localparam int SUM_W  = 64;
    localparam int ROWS_W = 11;

    localparam logic [ROWS_W-1:0] ROWS_MAX   = ROWS_W'(1024);
    localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(1024);

    localparam logic [SUM_W-1:0] SUM_POS_LIMIT = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_NEG_LIMIT = {1'b1, {(SUM_W-1){1'b0}}};

    // request codes
    localparam logic [1:0] REQ_VEC_WRITE = 2'd0;
    localparam logic [1:0] REQ_NONZERO   = 2'd1;
    localparam logic [1:0] REQ_EMPTY_ROW = 2'd2;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [COL_W-1:0]        column_index;
        logic signed [VAL_W-1:0] entry_value;
        logic                    row_end;
    } in_item_t;

    typedef struct packed {
        logic [COL_W-1:0]        row_index;
        logic signed [SUM_W-1:0] row_sum;
        logic                    saturated;
        logic                    last_row;
    } out_item_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_clr;
    } mac_ctrl_t;

endpackage

@@ rtl/core/csrspmv_vec_store.sv @@
module csrspmv_vec_store #(
    parameter int DEPTH = csrspmv_pkg::VECTOR_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         addr,
    input  logic [csrspmv_pkg::VAL_W-1:0]    wr_data,
    output logic [csrspmv_pkg::VAL_W-1:0]    rd_data
);

    logic [csrspmv_pkg::VAL_W-1:0] mem [DEPTH];
    logic [csrspmv_pkg::VAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/csrspmv_mac.sv @@
module csrspmv_mac (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  csrspmv_pkg::mac_ctrl_t                ctrl,
    input  logic signed [csrspmv_pkg::VAL_W-1:0]  mat_value,
    input  logic [csrspmv_pkg::VAL_W-1:0]         vec_data,
    input  logic                                  vec_valid,
    output logic signed [csrspmv_pkg::SUM_W-1:0]  acc_sum,
    output logic                                  acc_sat
);

    logic signed [csrspmv_pkg::VAL_W-1:0] vec_x;
    logic signed [csrspmv_pkg::SUM_W-1:0] prod_reg;
    logic signed [csrspmv_pkg::SUM_W-1:0] acc_reg;
    logic                                 sat_reg;
    logic [csrspmv_pkg::SUM_W-1:0]        sum_raw;
    logic                                 ovf;

    // columns beyond the store read as zero
    assign vec_x = vec_valid ? $signed(vec_data) : '0;

    assign sum_raw = acc_reg + prod_reg;
    assign ovf = (acc_reg[csrspmv_pkg::SUM_W-1] == prod_reg[csrspmv_pkg::SUM_W-1])
              && (sum_raw[csrspmv_pkg::SUM_W-1] != acc_reg[csrspmv_pkg::SUM_W-1]);

    always_comb
    begin
        if (ovf)
        begin
            acc_sum = acc_reg[csrspmv_pkg::SUM_W-1] ? $signed(csrspmv_pkg::SUM_NEG_LIMIT)
                                                    : $signed(csrspmv_pkg::SUM_POS_LIMIT);
        end
        else
        begin
            acc_sum = $signed(sum_raw);
        end
    end

    assign acc_sat = sat_reg | ovf;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= mat_value * vec_x;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end
        else if (ctrl.acc_clr)
        begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_sum;
            sat_reg <= acc_sat;
        end
    end

endmodule

@@ rtl/core/csr_sparse_matrix_vector_multiply.sv @@
// Sparse matrix times dense vector, fed in compressed-row order one beat at a time.
// A vector-write beat stores one Q16.16 element; a nonzero beat goes through the vector
// store read, a registered 32x32 multiply and a saturating 64-bit accumulate; an empty-row
// beat gives a zero row sum. The block works on one beat at a time, and a nonzero beat
// passes the single-port vector store with its registered read, then the registered
// multiplier. A finished row result sits in the output register, so the next
// beat is taken while it waits; a row end only holds the block if that register is
// still full. The vector store is not cleared at reset and needs no clearing pass:
// every column used by a nonzero must have been written first. num_rows of 0 acts as 1,
// values above 1024 act as 1024.
module csr_sparse_matrix_vector_multiply #(
    parameter int VECTOR_DEPTH = csrspmv_pkg::VECTOR_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [csrspmv_pkg::ROWS_W-1:0]     cfg_wr_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  csrspmv_pkg::in_item_t              in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output csrspmv_pkg::out_item_t             out_data
);

    localparam int ADDR_W = $clog2(VECTOR_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_EMPTY
    } state_t;

    state_t                                state_reg;
    logic [csrspmv_pkg::ROWS_W-1:0]        num_rows_reg;
    logic [csrspmv_pkg::COL_W-1:0]         row_counter_reg;
    logic signed [csrspmv_pkg::VAL_W-1:0]  item_value_reg;
    logic                                  item_end_reg;
    logic                                  item_in_range_reg;
    logic                                  out_valid_reg;
    csrspmv_pkg::out_item_t                out_data_reg;

    logic                                  accept;
    logic                                  in_range;
    logic [ADDR_W-1:0]                     vec_addr;
    logic                                  vec_wr_en;
    logic                                  vec_rd_en;
    logic [csrspmv_pkg::VAL_W-1:0]         vec_rd_data;
    logic                                  out_free;
    logic                                  emit;
    logic [csrspmv_pkg::ROWS_W-1:0]        rows_eff;
    logic [csrspmv_pkg::ROWS_W-1:0]        count_inc;
    logic                                  last;
    logic [csrspmv_pkg::COL_W-1:0]         row_counter_next;
    csrspmv_pkg::mac_ctrl_t                mac_ctrl;
    logic signed [csrspmv_pkg::SUM_W-1:0]  acc_sum;
    logic                                  acc_sat;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign in_range = (32'(in_data.column_index) < 32'(VECTOR_DEPTH));
    assign vec_addr = ADDR_W'(in_data.column_index);

    assign vec_wr_en = accept && (in_data.req_type == csrspmv_pkg::REQ_VEC_WRITE) && in_range;
    assign vec_rd_en = accept && (in_data.req_type == csrspmv_pkg::REQ_NONZERO);

    csrspmv_vec_store #(
        .DEPTH (VECTOR_DEPTH)
    ) u_vec_store (
        .clk     (clk),
        .wr_en   (vec_wr_en),
        .rd_en   (vec_rd_en),
        .addr    (vec_addr),
        .wr_data (in_data.entry_value),
        .rd_data (vec_rd_data)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign emit = out_free && (((state_reg == S_ACC) && item_end_reg) || (state_reg == S_EMPTY));

    always_comb
    begin
        mac_ctrl.mul_en  = (state_reg == S_MUL);
        mac_ctrl.acc_en  = (state_reg == S_ACC) && !item_end_reg;
        mac_ctrl.acc_clr = emit;
    end

    csrspmv_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .mat_value (item_value_reg),
        .vec_data  (vec_rd_data),
        .vec_valid (item_in_range_reg),
        .acc_sum   (acc_sum),
        .acc_sat   (acc_sat)
    );

    // row counting and last-row flag
    always_comb
    begin
        if (num_rows_reg == '0)
        begin
            rows_eff = csrspmv_pkg::ROWS_W'(1);
        end
        else if (num_rows_reg > csrspmv_pkg::ROWS_MAX)
        begin
            rows_eff = csrspmv_pkg::ROWS_MAX;
        end
        else
        begin
            rows_eff = num_rows_reg;
        end
    end

    assign count_inc        = {1'b0, row_counter_reg} + csrspmv_pkg::ROWS_W'(1);
    assign last             = (count_inc >= rows_eff);
    assign row_counter_next = last ? '0 : count_inc[csrspmv_pkg::COL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            num_rows_reg    <= csrspmv_pkg::ROWS_RESET;
            row_counter_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                num_rows_reg <= cfg_wr_data;
            end

            if (emit)
            begin
                out_valid_reg   <= 1'b1;
                row_counter_reg <= row_counter_next;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (in_data.req_type)
                            csrspmv_pkg::REQ_NONZERO:   state_reg <= S_MUL;
                            csrspmv_pkg::REQ_EMPTY_ROW: state_reg <= S_EMPTY;
                            default:                    state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (!item_end_reg || out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_EMPTY:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_value_reg    <= in_data.entry_value;
            item_end_reg      <= in_data.row_end;
            item_in_range_reg <= in_range;
        end
        if (emit)
        begin
            out_data_reg.row_index <= row_counter_reg;
            out_data_reg.last_row  <= last;
            if (state_reg == S_ACC)
            begin
                out_data_reg.row_sum   <= acc_sum;
                out_data_reg.saturated <= acc_sat;
            end
            else
            begin
                out_data_reg.row_sum   <= '0;
                out_data_reg.saturated <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
